[sv/kmnca_pkg.sv]
package kmnca_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    // item kinds carried in tuser
    localparam logic [1:0] OP_LOAD_CENTER = 2'd0;
    localparam logic [1:0] OP_SET_FLAGS   = 2'd1;
    localparam logic [1:0] OP_POINT       = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CLUSTER_COUNT = 2'd0;
    localparam logic [1:0] CFG_SEED_MODE     = 2'd1;
    localparam logic [1:0] CFG_SEED_CLUSTER  = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    localparam int OP_W   = 2;
    localparam int CI_W   = 4;
    localparam int DI_W   = 6;
    localparam int PC_W   = 5;
    localparam int DIST_W = 40;

    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

    // squares of differences of magnitude 2**SQ_LIMIT_BITS or more saturate
    localparam int SQ_LIMIT_BITS = 20;

    typedef logic [DIST_W-1:0] t_dist;

endpackage

[sv/kmeans_nearest_center_assign.sv]
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata, tuser = operation, tlast = last element
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata = nearest cluster result
// cfg       in   i_cfg_wr_en (no wait)          i_cfg_index, i_cfg_data
//
// Load-center and set-flags items are accepted while idle. A point element holds
// the input off while one multiply-accumulate pipe visits every cluster in turn,
// reading the partial-distance memory and, for all but the final element,
// writing it back. The final element then passes a flush state that hands the
// result to the output register, and waits there while that register is still full.
// Reset (synchronous, active low) clears flags, partial-distance valid bits, the
// element counter, state, output valid and configuration; not the center table.
// The output register lets the next item in while a result waits to be taken.
module kmeans_nearest_center_assign
    import kmnca_pkg::*;
#(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_DIMS     = 64,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // cluster_index, dim_index, sample_value, flag_changed, flag_valid,
    // prev_cluster, prev_distance, zero pad
    input  logic [((57+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  logic [OP_W-1:0]             s_axis_tuser,
    input  logic                        s_axis_tlast,

    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // nearest cluster, its squared distance, moved flag, zero pad
    output logic [47:0]                 m_axis_tdata,

    input  logic                        i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int CL_W  = $clog2(MAX_CLUSTERS);
    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CA_W  = $clog2(MAX_CLUSTERS * MAX_DIMS);
    localparam int DF_W  = SAMPLE_BITS + 1;
    localparam int MW    = (DF_W > SQ_LIMIT_BITS + 1) ? DF_W : SQ_LIMIT_BITS + 1;

    localparam int DI_LO = CI_W;
    localparam int SV_LO = DI_LO + DI_W;
    localparam int FC_B  = SV_LO + SAMPLE_BITS;
    localparam int FV_B  = FC_B + 1;
    localparam int PC_LO = FV_B + 1;
    localparam int PD_LO = PC_LO + PC_W;

    localparam logic [CL_W:0] NONE = (CL_W+1)'(MAX_CLUSTERS);

    // input fields
    logic [CI_W-1:0]        w_ci;
    logic [DI_W-1:0]        w_di;
    logic [SAMPLE_BITS-1:0] w_sv;
    logic                   w_fc;
    logic                   w_fv;
    logic [PC_W-1:0]        w_pc;
    t_dist                  w_pd;

    assign w_ci = s_axis_tdata[CI_W-1:0];
    assign w_di = s_axis_tdata[DI_LO +: DI_W];
    assign w_sv = s_axis_tdata[SV_LO +: SAMPLE_BITS];
    assign w_fc = s_axis_tdata[FC_B];
    assign w_fv = s_axis_tdata[FV_B];
    assign w_pc = s_axis_tdata[PC_LO +: PC_W];
    assign w_pd = s_axis_tdata[PD_LO +: DIST_W];

    // configuration
    logic [CFG_DATA_W-1:0] r_cluster_count;
    logic                  r_seed_mode;
    logic [CI_W-1:0]       r_seed_cluster;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= CFG_DATA_W'(1);
            r_seed_mode     <= 1'b0;
            r_seed_cluster  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CLUSTER_COUNT: r_cluster_count <= i_cfg_data;
                CFG_SEED_MODE:     r_seed_mode     <= i_cfg_data[0];
                CFG_SEED_CLUSTER:  r_seed_cluster  <= i_cfg_data[CI_W-1:0];
                default:           ;
            endcase
        end
    end

    // state machine
    t_state r_state, n_state;

    logic [CL_W:0] r_iss;
    logic          r_s1_v, r_s2_v;
    logic [CL_W-1:0] r_s1_idx, r_s2_idx;
    logic          r_m_valid;

    logic w_in_ready;
    logic w_accept;
    logic w_issue;
    logic w_sweep_done;
    logic w_load_out;

    assign w_accept     = s_axis_tvalid && w_in_ready;
    assign w_sweep_done = r_s2_v && (int'(r_s2_idx) == MAX_CLUSTERS - 1);

    logic r_last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && s_axis_tuser == OP_POINT) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (w_sweep_done) n_state = r_last ? ST_FLUSH : ST_IDLE;
            end
            ST_FLUSH: begin
                if (!r_m_valid || m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_issue    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE:  w_in_ready = 1'b1;
            ST_RUN:   w_issue    = (int'(r_iss) < MAX_CLUSTERS);
            ST_FLUSH: w_load_out = !r_m_valid || m_axis_tready;
            default:  ;
        endcase
    end

    assign s_axis_tready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // flags and point context
    logic [MAX_CLUSTERS-1:0] r_chg, r_vld;
    logic [DIM_W-1:0]        r_dim;
    logic [SAMPLE_BITS-1:0]  r_pt;
    logic [CL_W:0]           r_prev;
    logic                    r_seed;
    logic                    r_full;
    logic [CL_W:0]           r_best;
    t_dist                   r_best_dist;

    logic          w_ld_ok;
    logic [CL_W:0] w_prev;
    logic          w_full;

    assign w_ld_ok = (int'(w_ci) < MAX_CLUSTERS) && (int'(w_di) < MAX_DIMS);
    assign w_prev  = (int'(w_pc) >= MAX_CLUSTERS) ? NONE : (CL_W+1)'(w_pc);
    assign w_full  = (w_prev == NONE) || r_chg[w_prev[CL_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chg <= '0;
            r_vld <= '0;
        end else if (w_accept && s_axis_tuser == OP_SET_FLAGS
                     && int'(w_ci) < MAX_CLUSTERS) begin
            r_chg[CL_W'(w_ci)] <= w_fc;
            r_vld[CL_W'(w_ci)] <= w_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && s_axis_tuser == OP_POINT) begin
            r_pt   <= w_sv;
            r_prev <= w_prev;
            r_seed <= r_seed_mode;
            r_full <= w_full;
        end
    end

    // center table
    logic [SAMPLE_BITS-1:0] r_ctab [MAX_CLUSTERS*MAX_DIMS];
    logic [SAMPLE_BITS-1:0] r_c_rd;
    logic                   w_ctab_we;
    logic [CA_W-1:0]        w_ctab_waddr;
    logic [CA_W-1:0]        w_ctab_raddr;
    logic [CL_W-1:0]        w_iss_idx;

    assign w_iss_idx    = w_issue ? r_iss[CL_W-1:0] : '0;
    assign w_ctab_we    = w_accept && s_axis_tuser == OP_LOAD_CENTER && w_ld_ok;
    assign w_ctab_waddr = CA_W'(int'(w_ci) * MAX_DIMS + int'(w_di));
    assign w_ctab_raddr = CA_W'(int'(w_iss_idx) * MAX_DIMS + int'(r_dim));

    always_ff @(posedge i_clk) begin
        if (w_ctab_we) r_ctab[w_ctab_waddr] <= w_sv;
        r_c_rd <= r_ctab[w_ctab_raddr];
    end

    // partial distances; an entry without its valid bit reads as zero
    t_dist                   r_pmem [MAX_CLUSTERS];
    t_dist                   r_p_rd;
    logic [MAX_CLUSTERS-1:0] r_pvld;
    logic                    r_s1_pv;

    // stage 1: difference and square
    logic signed [DF_W-1:0] w_diff;
    logic [DF_W-1:0]        w_mag;
    logic [MW-1:0]          w_mag_w;
    logic                   w_big;
    t_dist                  r_s2_sq;
    t_dist                  r_s2_part;

    assign w_diff  = $signed({r_pt[SAMPLE_BITS-1], r_pt})
                   - $signed({r_c_rd[SAMPLE_BITS-1], r_c_rd});
    assign w_mag   = w_diff[DF_W-1] ? DF_W'(-w_diff) : DF_W'(w_diff);
    assign w_mag_w = MW'(w_mag);
    assign w_big   = |w_mag_w[MW-1:SQ_LIMIT_BITS];

    // stage 2: saturating accumulate and compare
    logic [DIST_W:0] w_sum_x;
    t_dist           w_sum;
    logic            w_elig;

    assign w_sum_x = {1'b0, r_s2_part} + {1'b0, r_s2_sq};
    assign w_sum   = w_sum_x[DIST_W] ? DIST_INF : w_sum_x[DIST_W-1:0];

    always_comb begin
        if (r_seed) begin
            w_elig = (int'(r_s2_idx) == int'(r_seed_cluster));
        end else begin
            w_elig = r_vld[r_s2_idx] && (int'(r_s2_idx) < int'(r_cluster_count))
                     && (r_full || r_chg[r_s2_idx]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v && !r_last) r_pmem[r_s2_idx] <= w_sum;
        r_p_rd <= r_pmem[w_iss_idx];
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx  <= w_iss_idx;
        r_s1_pv   <= r_pvld[w_iss_idx];
        r_s2_idx  <= r_s1_idx;
        r_s2_sq   <= w_big ? DIST_INF : DIST_W'(w_mag_w[SQ_LIMIT_BITS-1:0]
                                                * w_mag_w[SQ_LIMIT_BITS-1:0]);
        r_s2_part <= r_s1_pv ? r_p_rd : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss  <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_pvld <= '0;
            r_dim  <= '0;
            r_last <= 1'b0;
        end else begin
            r_s1_v <= w_issue;
            r_s2_v <= r_s1_v;
            if (w_accept && s_axis_tuser == OP_POINT) begin
                r_iss  <= '0;
                r_last <= s_axis_tlast;
            end else if (w_issue) begin
                r_iss <= r_iss + 1'b1;
            end
            if (r_s2_v && !r_last) r_pvld[r_s2_idx] <= 1'b1;
            if (w_sweep_done) begin
                if (r_last) begin
                    r_pvld <= '0;
                    r_dim  <= '0;
                end else if (int'(r_dim) + 1 >= MAX_DIMS) begin
                    r_dim <= '0;
                end else begin
                    r_dim <= r_dim + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && s_axis_tuser == OP_POINT) begin
            if (!r_seed_mode && w_full) begin
                r_best      <= NONE;
                r_best_dist <= DIST_INF;
            end else begin
                r_best      <= w_prev;
                r_best_dist <= w_pd;
            end
        end else if (r_s2_v && r_last && w_elig && w_sum < r_best_dist) begin
            r_best      <= {1'b0, r_s2_idx};
            r_best_dist <= w_sum;
        end
    end

    // output register
    logic [47:0] r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_m_data <= {2'b00, (r_best != r_prev), r_best_dist, PC_W'(r_best)};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import kmnca_pkg::*;

    localparam int CL_SLOTS = 16;
    localparam int NUM_DIMS = 64;
    localparam int IN_W = 80;
    localparam int OUT_W = 48;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [PC_W-1:0] NO_CLUSTER = 5'd16;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 750;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [CI_W-1:0] ci;
        logic [DI_W-1:0] di;
        logic [15:0]     sample;
        logic            chg;
        logic            vld;
        logic [PC_W-1:0] prev_cl;
        t_dist           prev_dist;
        logic            last;
    } t_stream_item;

    typedef struct {
        logic [PC_W-1:0] cl;
        t_dist           dist_sq;
        logic            moved;
    } t_assignment;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata;
    logic [OP_W-1:0]        s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_W-1:0]       m_axis_tdata;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // shadow of the block state
    logic [15:0]           centers [CL_SLOTS][NUM_DIMS];
    logic                  cl_changed [CL_SLOTS];
    logic                  cl_valid [CL_SLOTS];
    t_dist                 part_dist [CL_SLOTS];
    logic [DI_W-1:0]       elem_idx;
    logic [CFG_DATA_W-1:0] cfg_count;
    logic                  cfg_seed;
    logic [3:0]            cfg_seed_cl;

    t_assignment assign_q[$];
    int mismatches = 0;
    int cycles = 0;
    bit src_gaps = 1'b0;
    bit sink_stalls;
    int sink_hold;
    int sink_phase;

    kmeans_nearest_center_assign dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_dist sq_diff(logic [15:0] p, logic [15:0] c);
        int d;
        longint mag;
        d = int'($signed(p)) - int'($signed(c));
        mag = (d < 0) ? -d : d;
        if (mag >= (longint'(1) << SQ_LIMIT_BITS))
            return DIST_INF;
        return t_dist'(mag * mag);
    endfunction

    function automatic t_dist sat_accum(t_dist a, t_dist b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, DIST_INF}) ? DIST_INF : s[DIST_W-1:0];
    endfunction

    task automatic predict_item(input t_stream_item it);
        t_assignment res;
        logic [PC_W-1:0] prev;
        int n;
        case (it.op)
            OP_LOAD_CENTER: begin
                centers[it.ci][it.di] = it.sample;
            end
            OP_SET_FLAGS: begin
                cl_changed[it.ci] = it.chg;
                cl_valid[it.ci] = it.vld;
            end
            OP_POINT: begin
                for (int c = 0; c < CL_SLOTS; c++)
                    part_dist[c] = sat_accum(part_dist[c],
                                             sq_diff(it.sample, centers[c][elem_idx]));
                elem_idx = elem_idx + 1'b1;
                if (it.last) begin
                    prev = (it.prev_cl >= NO_CLUSTER) ? NO_CLUSTER : it.prev_cl;
                    n = (cfg_count > CL_SLOTS) ? CL_SLOTS : int'(cfg_count);
                    if (cfg_seed) begin
                        res.cl = prev;
                        res.dist_sq = it.prev_dist;
                        if (it.prev_dist > part_dist[cfg_seed_cl]) begin
                            res.cl = {1'b0, cfg_seed_cl};
                            res.dist_sq = part_dist[cfg_seed_cl];
                        end
                    end else if (prev == NO_CLUSTER || cl_changed[prev[3:0]]) begin
                        res.cl = NO_CLUSTER;
                        res.dist_sq = DIST_INF;
                        for (int i = 0; i < n; i++)
                            if (cl_valid[i] && part_dist[i] < res.dist_sq) begin
                                res.cl = PC_W'(i);
                                res.dist_sq = part_dist[i];
                            end
                    end else begin
                        res.cl = prev;
                        res.dist_sq = it.prev_dist;
                        for (int i = 0; i < n; i++)
                            if (cl_valid[i] && cl_changed[i]
                                && part_dist[i] < res.dist_sq) begin
                                res.cl = PC_W'(i);
                                res.dist_sq = part_dist[i];
                            end
                    end
                    res.moved = (res.cl != prev);
                    assign_q = {assign_q, res};
                    for (int c = 0; c < CL_SLOTS; c++)
                        part_dist[c] = '0;
                    elem_idx = '0;
                end
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_dist pick_prev_dist();
        case ($urandom_range(0, 5))
            0: return DIST_INF;
            1: return '0;
            2: return t_dist'({$urandom, $urandom});
            3: return DIST_INF - 1;
            default: return t_dist'({$urandom_range(0, 7), $urandom});
        endcase
    endfunction

    function automatic logic [PC_W-1:0] pick_prev_cluster();
        case ($urandom_range(0, 9))
            0: return NO_CLUSTER;
            1: return PC_W'($urandom_range(17, 31));
            default: return PC_W'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_count();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'($urandom_range(17, 31));
            default: return 5'($urandom_range(1, 16));
        endcase
    endfunction

    // all fields random; callers override what matters
    function automatic t_stream_item rand_item(logic [OP_W-1:0] op);
        t_stream_item it;
        it.op = op;
        it.ci = CI_W'($urandom);
        it.di = DI_W'($urandom);
        it.sample = 16'($urandom);
        it.chg = 1'($urandom);
        it.vld = 1'($urandom);
        it.prev_cl = PC_W'($urandom);
        it.prev_dist = t_dist'({$urandom, $urandom});
        it.last = 1'($urandom);
        return it;
    endfunction

    task automatic send_item(input t_stream_item it);
        int gap;
        gap = src_gaps ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        // tdata: ci, di, sample, changed, valid, prev cluster, prev distance, pad
        s_axis_tdata = {7'd0, it.prev_dist, it.prev_cl, it.vld, it.chg, it.sample, it.di, it.ci};
        s_axis_tuser = it.op;
        s_axis_tlast = it.last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(it);
    endtask

    task automatic load_center(input logic [CI_W-1:0] ci, input logic [DI_W-1:0] di,
                               input logic [15:0] value);
        t_stream_item it;
        it = rand_item(OP_LOAD_CENTER);
        it.ci = ci;
        it.di = di;
        it.sample = value;
        send_item(it);
    endtask

    task automatic set_flags(input logic [CI_W-1:0] ci, input logic chg, input logic vld);
        t_stream_item it;
        it = rand_item(OP_SET_FLAGS);
        it.ci = ci;
        it.chg = chg;
        it.vld = vld;
        send_item(it);
    endtask

    task automatic send_point(input int len, input logic [PC_W-1:0] prev_cl,
                              input t_dist prev_dist, input bit max_sample);
        t_stream_item it;
        for (int e = 0; e < len; e++) begin
            it = rand_item(OP_POINT);
            it.sample = max_sample ? 16'h7FFF : pick_sample();
            it.last = (e == len - 1);
            if (it.last) begin
                it.prev_cl = prev_cl;
                it.prev_dist = prev_dist;
            end
            send_item(it);
        end
    endtask

    // a non-last point element gives no result, so wait out its pipe too
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (assign_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] count, input logic seed,
                              input logic [3:0] seed_cl);
        wait_idle();
        i_cfg_wr_en = 1'b1;
        i_cfg_index = CFG_CLUSTER_COUNT;
        i_cfg_data = count;
        @(negedge i_clk);
        i_cfg_index = CFG_SEED_MODE;
        i_cfg_data = {4'd0, seed};
        @(negedge i_clk);
        i_cfg_index = CFG_SEED_CLUSTER;
        i_cfg_data = {1'b0, seed_cl};
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        cfg_count = count;
        cfg_seed = seed;
        cfg_seed_cl = seed_cl;
    endtask

    // every entry is written before the first point reads it
    task automatic test_fill_table();
        src_gaps = 1'b1;
        for (int c = 0; c < CL_SLOTS; c++)
            for (int d = 0; d < NUM_DIMS; d++)
                load_center(CI_W'(c), DI_W'(d), pick_sample());
        send_item(rand_item(OP_UNUSED));
        send_item(rand_item(OP_UNUSED));
    endtask

    task automatic test_search_rules();
        set_config(5'd4, 1'b0, 4'd0);
        set_flags(4'd0, 1'b0, 1'b1);
        set_flags(4'd1, 1'b1, 1'b1);
        set_flags(4'd2, 1'b1, 1'b0);
        set_flags(4'd3, 1'b0, 1'b1);
        // cluster 3 ties cluster 0 on the first dims; the earlier one must win
        for (int d = 0; d < 4; d++)
            load_center(4'd3, DI_W'(d), centers[0][d]);
        send_point(4, NO_CLUSTER, pick_prev_dist(), 1'b0);
        send_point(4, 5'd17, DIST_INF, 1'b0);
        send_point(3, 5'd31, '0, 1'b0);
        send_point(4, 5'd1, '0, 1'b0);
        send_point(4, 5'd0, '0, 1'b0);
        send_point(4, 5'd0, DIST_INF, 1'b0);
        send_point(4, 5'd2, DIST_INF, 1'b0);
        send_point(1, 5'd3, pick_prev_dist(), 1'b0);
    endtask

    task automatic test_count_extremes();
        set_config(5'd0, 1'b0, 4'd0);
        send_point(2, NO_CLUSTER, pick_prev_dist(), 1'b0);
        send_point(2, 5'd3, t_dist'(12345), 1'b0);
        for (int c = 4; c < CL_SLOTS; c++)
            set_flags(CI_W'(c), 1'($urandom), 1'b1);
        set_config(5'd31, 1'b0, 4'd0);
        send_point(5, NO_CLUSTER, DIST_INF, 1'b0);
        send_point(5, 5'd15, pick_prev_dist(), 1'b0);
        set_config(5'd16, 1'b0, 4'd0);
        send_point(2, 5'd9, pick_prev_dist(), 1'b0);
    endtask

    task automatic test_seed_mode();
        set_config(5'd1, 1'b1, 4'd15);
        send_point(3, NO_CLUSTER, DIST_INF, 1'b0);
        send_point(3, 5'd4, '0, 1'b0);
        send_point(3, 5'd20, pick_prev_dist(), 1'b0);
        set_config(5'd16, 1'b1, 4'd0);
        send_point(2, 5'd0, DIST_INF, 1'b0);
        send_point(2, 5'd7, pick_prev_dist(), 1'b0);
    endtask

    // points longer than the table depth reuse the first dimensions
    task automatic test_element_wrap();
        set_config(5'd16, 1'b0, 4'd0);
        send_point(70, NO_CLUSTER, DIST_INF, 1'b0);
        send_point(64, 5'd5, pick_prev_dist(), 1'b0);
    endtask

    // max-span terms pile past 2^40 - 1; a saturated distance never beats infinity
    task automatic test_saturation();
        set_config(5'd3, 1'b0, 4'd2);
        set_flags(4'd0, 1'b1, 1'b0);
        set_flags(4'd1, 1'b0, 1'b0);
        set_flags(4'd2, 1'b0, 1'b1);
        for (int d = 0; d < NUM_DIMS; d++)
            load_center(4'd2, DI_W'(d), 16'h8000);
        send_point(300, NO_CLUSTER, DIST_INF, 1'b1);
    endtask

    task automatic test_random();
        t_stream_item it;
        int sent;
        int phase_len;
        int k;
        int r;
        int len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            set_config(pick_count(), ($urandom_range(0, 3) == 0), 4'($urandom));
            src_gaps = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(60, 120);
            k = 0;
            while (k < phase_len && sent < RANDOM_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70)
                                                        : $urandom_range(1, 6);
                    send_point(len, pick_prev_cluster(), pick_prev_dist(), 1'b0);
                    sent += len;
                end else if (r < 78) begin
                    it = rand_item(OP_LOAD_CENTER);
                    it.sample = pick_sample();
                    send_item(it);
                    sent++;
                end else if (r < 92) begin
                    it = rand_item(OP_SET_FLAGS);
                    it.vld = ($urandom_range(0, 3) != 0);
                    send_item(it);
                    sent++;
                end else begin
                    send_item(rand_item(OP_UNUSED));
                end
                k++;
            end
        end
    endtask

    // result sink with bursts of stalls and stall-free stretches
    initial begin
        m_axis_tready = 1'b0;
        sink_hold = 0;
        sink_phase = 0;
        sink_stalls = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_phase == 0) begin
                sink_stalls = ($urandom_range(0, 3) != 0);
                sink_phase = $urandom_range(50, 400);
            end else begin
                sink_phase--;
            end
            if (sink_hold > 0) begin
                m_axis_tready = 1'b0;
                sink_hold--;
            end else begin
                m_axis_tready = 1'b1;
                if (sink_stalls && $urandom_range(0, 2) == 0)
                    sink_hold = pick_gap();
            end
        end
    end

    // result item: nearest cluster, its distance, moved flag
    always @(posedge i_clk) begin
        t_assignment want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (assign_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected, got %h", $time, m_axis_tdata);
            end else begin
                want = assign_q.pop_front();
                if (m_axis_tdata[4:0] !== want.cl) begin
                    mismatches++;
                    $display("%0t: nearest cluster expected %0d got %0d",
                             $time, want.cl, m_axis_tdata[4:0]);
                end
                if (m_axis_tdata[44:5] !== want.dist_sq) begin
                    mismatches++;
                    $display("%0t: nearest distance expected %h got %h",
                             $time, want.dist_sq, m_axis_tdata[44:5]);
                end
                if (m_axis_tdata[45] !== want.moved) begin
                    mismatches++;
                    $display("%0t: assignment_changed expected %b got %b",
                             $time, want.moved, m_axis_tdata[45]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_LOAD_CENTER;
        s_axis_tlast = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_CLUSTER_COUNT;
        i_cfg_data = '0;
        for (int c = 0; c < CL_SLOTS; c++) begin
            cl_changed[c] = 1'b0;
            cl_valid[c] = 1'b0;
            part_dist[c] = '0;
            for (int d = 0; d < NUM_DIMS; d++)
                centers[c][d] = '0;
        end
        elem_idx = '0;
        cfg_count = 5'd1;
        cfg_seed = 1'b0;
        cfg_seed_cl = 4'd0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_fill_table();
        test_search_rules();
        test_count_extremes();
        test_seed_mode();
        test_element_wrap();
        test_saturation();
        test_random();

        wait_idle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
sv/kmnca_pkg.sv
sv/kmeans_nearest_center_assign.sv
tb/tb.sv
